### hdl/gsps_pkg.sv
// Gas sensor poll sequencer: shared types, codes and the CRC-8 byte step.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gsps_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SRST = 3'd1,
        PH_INIT = 3'd2,
        PH_MEAS = 3'd3,
        PH_READ = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_SRST = 3'd1,
        ACT_INIT = 3'd2,
        ACT_MEAS = 3'd3,
        ACT_READ = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_CLR_MAX = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    localparam logic [3:0] TIMEOUT_RST = 4'd5;
    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [7:0] CRC_INIT    = 8'hFF;

    typedef struct packed {
        logic [7:0] voc_check;
        logic [7:0] voc_low;
        logic [7:0] voc_high;
        logic       bus_ack;
        logic [1:0] cmd;
    } t_item;

    typedef struct packed {
        logic [15:0] voc_peak;
        logic [15:0] voc_value;
        logic        value_valid;
        logic        ready_res;
        logic [2:0]  phase_now;
        logic [2:0]  bus_action;
    } t_result;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/gsps_crc8.sv
// CRC-8 check (poly 0x31, init 0xFF) over the high then the low VOC byte.
// Depends on gsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsps_crc8 (
    input  wire logic [7:0] i_high,
    input  wire logic [7:0] i_low,
    input  wire logic [7:0] i_check,
    output logic            o_match
);
    import gsps_pkg::*;

    logic [7:0] crc_hi;
    logic [7:0] crc_lo;

    assign crc_hi  = crc8_byte(CRC_INIT, i_high);
    assign crc_lo  = crc8_byte(crc_hi, i_low);
    assign o_match = (crc_lo == i_check);

endmodule

`default_nettype wire

### hdl/gsps_step.sv
// Sequencer state, per-request next-state logic and the result register.
// Depends on gsps_pkg and gsps_crc8.
`timescale 1ns / 1ps
`default_nettype none

module gsps_step (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [3:0]       i_limit,
    input  wire logic             i_vld,
    input  wire gsps_pkg::t_item  i_item,
    output logic                  o_take,
    output logic                  o_vld,
    input  wire logic             i_rdy,
    output gsps_pkg::t_result     o_res
);
    import gsps_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_stall, n_stall;
    logic [15:0] r_last, n_last;
    logic [15:0] r_peak, n_peak;
    logic        r_out_vld;
    t_result     r_res, n_res;
    t_action     act;
    logic        valid;
    logic        crc_ok;
    logic [15:0] word;
    t_phase      ph_in;

    gsps_crc8 u_crc (
        .i_high  (i_item.voc_high),
        .i_low   (i_item.voc_low),
        .i_check (i_item.voc_check),
        .o_match (crc_ok)
    );

    assign o_take = i_vld && (!r_out_vld || i_rdy);
    assign word   = {i_item.voc_high, i_item.voc_low};
    assign ph_in  = (t_cmd'(i_item.cmd) == CMD_RESTART) ? PH_IDLE : r_phase;

    always_comb begin
        n_phase = r_phase;
        n_stall = r_stall;
        n_last  = r_last;
        n_peak  = r_peak;
        act     = ACT_NONE;
        valid   = 1'b0;
        unique case (t_cmd'(i_item.cmd))
            CMD_CLR_MAX: begin
                n_peak = '0;
            end
            CMD_TICK, CMD_RESTART: begin
                n_phase = ph_in;
                if (r_stall >= i_limit) begin
                    n_phase = PH_SRST;
                    n_stall = '0;
                end else begin
                    n_stall = r_stall + 4'd1;
                    unique case (ph_in)
                        PH_SRST: begin
                            act = ACT_SRST;
                            if (i_item.bus_ack) begin
                                n_phase = PH_INIT;
                                n_stall = '0;
                            end
                        end
                        PH_INIT: begin
                            act = ACT_INIT;
                            if (i_item.bus_ack) begin
                                n_phase = PH_MEAS;
                                n_stall = '0;
                            end
                        end
                        PH_MEAS: begin
                            act = ACT_MEAS;
                            if (i_item.bus_ack) begin
                                n_phase = PH_READ;
                                n_stall = '0;
                            end
                        end
                        PH_READ: begin
                            act = ACT_READ;
                            if (i_item.bus_ack) begin
                                n_stall = '0;
                                if (crc_ok) begin
                                    n_last  = word;
                                    valid   = 1'b1;
                                    n_phase = PH_MEAS;
                                    if (word > r_peak) begin
                                        n_peak = word;
                                    end
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_INIT;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
        n_res.bus_action  = act;
        n_res.phase_now   = n_phase;
        n_res.ready_res   = (n_phase == PH_MEAS);
        n_res.value_valid = valid;
        n_res.voc_value   = n_last;
        n_res.voc_peak    = n_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_stall   <= '0;
            r_last    <= '0;
            r_peak    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase   <= n_phase;
                r_stall   <= n_stall;
                r_last    <= n_last;
                r_peak    <= n_peak;
                r_out_vld <= 1'b1;
            end else if (i_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_out_vld;
    assign o_res = r_res;

`ifndef SYNTH
    a_valid_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.value_valid) |->
        (r_res.bus_action == ACT_READ && r_res.phase_now == PH_MEAS))
        else $error("accepted reading without a read transfer");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.value_valid) |-> (r_res.voc_peak >= r_res.voc_value))
        else $error("peak below accepted reading");

    a_clear_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && t_cmd'(i_item.cmd) == CMD_CLR_MAX) |=> (r_peak == '0))
        else $error("clear did not zero the peak");
`endif

endmodule

`default_nettype wire

### hdl/gas_sensor_poll_sequencer_unit.sv
// Gas sensor poll sequencer top level: input register, limit register, step stage.
// Depends on gsps_pkg and gsps_step.
//
// Usage:
//  - Requests enter on the s-side stream; each gives exactly one result on the
//    m-side stream. tuser carries cmd, tdata the acknowledge and the VOC bytes.
//  - The timeout limit is written on the cfg channel (always ready); the user
//    must write it only while idle, the block does not enforce this.
//  - A request passes the input register, then the result register, which is
//    loaded together with the sequencer state.
//  - Throughput: one request per cycle while the receiver takes results; the
//    phase, stall counter and peak registers update with each request.
//  - When the receiver stalls, the result register holds and the input
//    register still takes one more request; tready then drops until the
//    result is taken.
//  - Reset (i_rst_n low, synchronous): phase idle, stall count, last and peak
//    readings zero, timeout limit 5, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module gas_sensor_poll_sequencer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data,   // timeout_limit
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata, // bus_ack, voc_high, voc_low, voc_check, zero pad
    input  wire logic [1:0]  s_axis_tuser, // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata  // bus_action, phase_now, ready_res, value_valid,
                                           // voc_value, voc_peak
);
    import gsps_pkg::*;

    logic [3:0] r_limit;
    logic       r_in_vld;
    t_item      r_item;
    logic       step_take;
    t_result    res;
    logic       s_fire;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_in_vld || step_take;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= TIMEOUT_RST;
            r_in_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (s_fire) begin
                r_in_vld <= 1'b1;
            end else if (step_take) begin
                r_in_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_item.cmd       <= s_axis_tuser;
            r_item.bus_ack   <= s_axis_tdata[0];
            r_item.voc_high  <= s_axis_tdata[8:1];
            r_item.voc_low   <= s_axis_tdata[16:9];
            r_item.voc_check <= s_axis_tdata[24:17];
        end
    end

    gsps_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_limit (r_limit),
        .i_vld   (r_in_vld),
        .i_item  (r_item),
        .o_take  (step_take),
        .o_vld   (m_axis_tvalid),
        .i_rdy   (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = res;

endmodule

`default_nettype wire
